### design/tlsb_pkg.sv
// ---------------------------------------------------------------------------
// tlsb_pkg
// Shared constants and types for the text line scrollback buffer.
// ---------------------------------------------------------------------------
package tlsb_pkg;

  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 28;
  localparam int SCROLLBACK = 100;

  // Physical line slots: every stored line plus the line being built, so the
  // line under construction never shares a slot with a stored line.
  localparam int SLOTS      = MAX_ROWS + SCROLLBACK + 1;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int LEN_W      = COL_W + 1;
  localparam int CHAR_AW    = SLOT_W + COL_W;
  localparam int CHAR_DEPTH = SLOTS * MAX_COLS;

  localparam int TAB_SPACES = 4;
  localparam int TAB_W      = $clog2(TAB_SPACES + 1);
  localparam int SUB_W      = $clog2(TAB_SPACES);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Fixed field widths
  localparam int CHAR_W  = 8;
  localparam int LINE_W  = 7;
  localparam int COUNT_W = 8;
  localparam int ROWS_W  = 5;

  localparam logic REG_COLUMNS     = 1'b0;
  localparam logic REG_SCREEN_ROWS = 1'b1;

  typedef enum logic {
    CMD_FEED = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_START = 2'd1,
    ESC_SEQ   = 2'd2
  } esc_phase_e;

  typedef struct packed {
    logic [COUNT_W-1:0] line_count;
    logic [LINE_W-1:0]  cursor_row;
    logic [CHAR_W-1:0]  current_length;
    logic               dropped;
  } res_t;

  // One request as handed from the front to the back
  typedef struct packed {
    logic               is_read;
    logic               line_ok;
    logic [SLOT_W-1:0]  slot;
    logic [COL_W-1:0]   col;
    logic [CHAR_W-1:0]  wr_char;
    logic [TAB_W-1:0]   wr_cnt;
    logic               len_we;
    logic [LEN_W-1:0]   len_val;
    res_t               res;
  } op_t;

endpackage

### design/text_line_scrollback_buffer.sv
// ---------------------------------------------------------------------------
// text_line_scrollback_buffer
// Scrollback store of text lines built from a shell output byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one request per accepted edge.
//   cmd_i = feed hands byte_in_i to the line builder; cmd_i = read looks up
//   read_line_i / read_col_i in the committed lines, oldest line first.
//   Output channel (out_valid_o / out_stall_i): exactly one result per
//   request, in request order, carrying the read character and the line
//   state (count, cursor row, current length, oldest-line drop flag).
//   Config port: cfg_we_i writes cfg_data_i to register cfg_index_i
//   (0 = columns, 1 = screen_rows) in the same edge; write only when idle.
// Result path: a request is registered in a queue slot, then in the output
//   register; a tab stays at the queue head until its last space is written.
// Throughput: one request per cycle while the output is not stalled; a tab
//   holds the back end for one character-memory write per space.
// A four-entry queue decouples the classifier from the line store.
// Reset: one empty line stored, columns 80, screen_rows 24, queue empty.
//   The character memory needs no clearing pass.
// Receiver stall: the output register holds its result; the queue absorbs
//   up to four more requests before in_stall_o rises.
// ---------------------------------------------------------------------------
module text_line_scrollback_buffer import tlsb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CHAR_W-1:0]   cfg_data_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [CHAR_W-1:0]   byte_in_i,
  input  logic [LINE_W-1:0]   read_line_i,
  input  logic [COL_W-1:0]    read_col_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CHAR_W-1:0]   read_char_o,
  output logic                read_valid_o,
  output logic [COUNT_W-1:0]  line_count_o,
  output logic [LINE_W-1:0]   cursor_row_o,
  output logic [CHAR_W-1:0]   current_length_o,
  output logic                dropped_oldest_o
);

  logic push;
  op_t  push_op;
  logic fifo_full;
  logic head_valid;
  op_t  head_op;
  logic pop;

  // Front: escape framing, line length, ring pointers; one request a cycle while the queue is not full
  tlsb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .full_i      (fifo_full),
    .cmd_i       (cmd_i),
    .byte_in_i   (byte_in_i),
    .read_line_i (read_line_i),
    .read_col_i  (read_col_i),
    .push_o      (push),
    .op_o        (push_op)
  );

  assign in_stall_o = fifo_full;

  tlsb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_op)
  );

  // Back: memory writes and reads in request order, output register
  tlsb_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head_op),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_char_o      (read_char_o),
    .read_valid_o     (read_valid_o),
    .line_count_o     (line_count_o),
    .cursor_row_o     (cursor_row_o),
    .current_length_o (current_length_o),
    .dropped_oldest_o (dropped_oldest_o)
  );

endmodule

### design/tlsb_front.sv
// ---------------------------------------------------------------------------
// tlsb_front
// Byte classifier: escape tracking, line length, ring pointers, commits.
// ---------------------------------------------------------------------------
module tlsb_front import tlsb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CHAR_W-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  input  logic                full_i,
  input  logic                cmd_i,
  input  logic [CHAR_W-1:0]   byte_in_i,
  input  logic [LINE_W-1:0]   read_line_i,
  input  logic [COL_W-1:0]    read_col_i,
  output logic                push_o,
  output op_t                 op_o
);

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1b;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7f;
  localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5b;
  localparam logic [CHAR_W-1:0] CH_FIN_M = 8'h6d;
  localparam logic [CHAR_W-1:0] CH_FIN_H = 8'h48;
  localparam logic [CHAR_W-1:0] CH_FIN_J = 8'h4a;
  localparam logic [CHAR_W-1:0] CH_FIN_K = 8'h4b;
  localparam logic [CHAR_W-1:0] CH_FIN_h = 8'h68;
  localparam logic [CHAR_W-1:0] CH_FIN_l = 8'h6c;

  localparam logic [CHAR_W-1:0] COLUMNS_RESET = 8'd80;
  localparam logic [ROWS_W-1:0] ROWS_RESET    = 5'd24;

  function automatic logic is_final(input logic [CHAR_W-1:0] b);
    return (b == CH_FIN_M) || (b == CH_FIN_H) || (b == CH_FIN_J) ||
           (b == CH_FIN_K) || (b == CH_FIN_h) || (b == CH_FIN_l);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  logic [CHAR_W-1:0]  columns_q;
  logic [ROWS_W-1:0]  rows_q;
  esc_phase_e         phase_q, phase_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [SLOT_W-1:0]  oldest_q, oldest_d;
  logic [SLOT_W-1:0]  build_q, build_d;
  logic [COUNT_W-1:0] stored_q, stored_d;
  logic [LINE_W-1:0]  cursor_q, cursor_d;

  logic               accept;
  logic               text_byte;
  logic [LEN_W-1:0]   cols_eff;
  logic [ROWS_W-1:0]  rows_eff;
  logic [COUNT_W-1:0] limit;
  logic               drop;
  logic [LEN_W-1:0]   room;
  logic [TAB_W-1:0]   tab_n;
  logic [SLOT_W:0]    rd_sum;
  logic [SLOT_W-1:0]  rd_slot;

  assign accept = in_valid_i && !full_i;
  assign push_o = accept;

  // Bytes that reach the text handler (the '[' after ESC and sequence bytes do not)
  assign text_byte = (cmd_i == CMD_FEED) && (phase_q != ESC_SEQ) &&
                     !((phase_q == ESC_START) && (byte_in_i == CH_LBRK));

  always_comb begin
    cols_eff = (columns_q == '0) ? LEN_W'(1) : {1'b0, columns_q};
    if (cols_eff > LEN_W'(MAX_COLS)) cols_eff = LEN_W'(MAX_COLS);
    rows_eff = (rows_q == '0) ? ROWS_W'(1) : rows_q;
    if (rows_eff > ROWS_W'(MAX_ROWS)) rows_eff = ROWS_W'(MAX_ROWS);
  end

  assign limit = COUNT_W'(rows_eff) + COUNT_W'(SCROLLBACK);
  assign drop  = (stored_q >= limit);
  assign room  = (len_q < cols_eff) ? (cols_eff - len_q) : '0;
  assign tab_n = (room >= LEN_W'(TAB_SPACES)) ? TAB_W'(TAB_SPACES) : room[TAB_W-1:0];

  assign rd_sum  = {1'b0, oldest_q} + (SLOT_W+1)'(read_line_i);
  assign rd_slot = (rd_sum >= (SLOT_W+1)'(SLOTS)) ?
                   SLOT_W'(rd_sum - (SLOT_W+1)'(SLOTS)) : rd_sum[SLOT_W-1:0];

  // Escape phase next state
  always_comb begin
    phase_d = phase_q;
    if (cmd_i == CMD_FEED) begin
      case (phase_q)
        ESC_SEQ: begin
          if (is_final(byte_in_i)) phase_d = ESC_NONE;
        end
        ESC_START: begin
          if (byte_in_i == CH_LBRK)     phase_d = ESC_SEQ;
          else if (byte_in_i == CH_ESC) phase_d = ESC_START;
          else                          phase_d = ESC_NONE;
        end
        default: begin
          phase_d = (byte_in_i == CH_ESC) ? ESC_START : ESC_NONE;
        end
      endcase
    end
  end

  // Line state and request build
  always_comb begin
    logic             commit;
    logic             by_nl;
    logic [LEN_W-1:0] len_app;

    commit   = 1'b0;
    by_nl    = 1'b0;
    len_app  = len_q;
    len_d    = len_q;
    oldest_d = oldest_q;
    build_d  = build_q;
    stored_d = stored_q;
    cursor_d = cursor_q;

    op_o         = '0;
    op_o.slot    = build_q;
    op_o.col     = len_q[COL_W-1:0];
    op_o.wr_char = byte_in_i;

    if (cmd_i == CMD_READ) begin
      op_o.is_read = 1'b1;
      op_o.line_ok = (COUNT_W'(read_line_i) < stored_q);
      op_o.slot    = rd_slot;
      op_o.col     = read_col_i;
    end else if (text_byte) begin
      if (byte_in_i == CH_LF) begin
        commit = 1'b1;
        by_nl  = 1'b1;
      end else if ((byte_in_i == CH_BS) || (byte_in_i == CH_DEL)) begin
        if (len_q != '0) len_d = len_q - LEN_W'(1);
      end else if ((byte_in_i >= CH_SPACE) && (byte_in_i < CH_DEL)) begin
        if (len_q < LEN_W'(MAX_COLS)) begin
          op_o.wr_cnt = TAB_W'(1);
          len_app     = len_q + LEN_W'(1);
        end
        len_d = len_app;
        if (len_app >= cols_eff) commit = 1'b1;
      end else if (byte_in_i == CH_TAB) begin
        op_o.wr_char = CH_SPACE;
        op_o.wr_cnt  = tab_n;
        len_d        = len_q + LEN_W'(tab_n);
      end
    end

    if (commit) begin
      op_o.len_we  = 1'b1;
      op_o.len_val = len_d;
      if (drop) oldest_d = slot_inc(oldest_q);
      stored_d = drop ? stored_q : stored_q + COUNT_W'(1);
      if (by_nl) begin
        cursor_d = LINE_W'(stored_d - COUNT_W'(1));
      end else if (drop && (cursor_q != '0)) begin
        cursor_d = cursor_q - LINE_W'(1);
      end
      len_d   = '0;
      build_d = slot_inc(build_q);
    end

    op_o.res.line_count     = stored_d;
    op_o.res.cursor_row     = cursor_d;
    op_o.res.current_length = len_d[CHAR_W-1:0];
    op_o.res.dropped        = commit && drop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RESET;
      rows_q    <= ROWS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COLUMNS:     columns_q <= cfg_data_i;
        REG_SCREEN_ROWS: rows_q    <= cfg_data_i[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ESC_NONE;
      len_q    <= '0;
      oldest_q <= '0;
      build_q  <= SLOT_W'(1);
      stored_q <= COUNT_W'(1);
      cursor_q <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      oldest_q <= oldest_d;
      build_q  <= build_d;
      stored_q <= stored_d;
      cursor_q <= cursor_d;
    end
  end

endmodule

### design/tlsb_fifo.sv
// ---------------------------------------------------------------------------
// tlsb_fifo
// Short request queue between front and back.
// ---------------------------------------------------------------------------
module tlsb_fifo import tlsb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  data_o
);

  op_t                entries_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (FIFO_AW+1)'(1);
        2'b01:   count_q <= count_q - (FIFO_AW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### design/tlsb_back.sv
// ---------------------------------------------------------------------------
// tlsb_back
// Line store: character and length memories, tab expansion, output register.
// ---------------------------------------------------------------------------
module tlsb_back import tlsb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  op_t                 head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CHAR_W-1:0]   read_char_o,
  output logic                read_valid_o,
  output logic [COUNT_W-1:0]  line_count_o,
  output logic [LINE_W-1:0]   cursor_row_o,
  output logic [CHAR_W-1:0]   current_length_o,
  output logic                dropped_oldest_o
);

  logic [CHAR_W-1:0] char_mem [CHAR_DEPTH];
  logic [LEN_W-1:0]  len_mem  [SLOTS];

  logic [SUB_W-1:0]   sub_q;
  logic               len0_set_q;
  logic               out_valid_q;
  res_t               res_q;
  logic               is_read_q;
  logic               line_ok_q;
  logic [COL_W-1:0]   col_q;
  logic               len_zero_q;
  logic [CHAR_W-1:0]  char_rd_q;
  logic [LEN_W-1:0]   len_rd_q;

  logic               last;
  logic               b_ready;
  logic               step;
  logic               char_we;
  logic [CHAR_AW-1:0] char_addr;
  logic [LEN_W-1:0]   len_eff;
  logic               hit;

  // Tab requests write one space per cycle; the result leaves on the last one, which waits while the output is stalled
  assign last      = (TAB_W'(sub_q) + TAB_W'(1)) >= head_i.wr_cnt;
  assign b_ready   = !out_valid_q || !out_stall_i;
  assign step      = head_valid_i && (!last || b_ready);
  assign pop_o     = step && last;
  assign char_we   = step && !head_i.is_read && (head_i.wr_cnt != '0);
  assign char_addr = {head_i.slot, head_i.col + COL_W'(sub_q)};

  always_ff @(posedge clk_i) begin
    if (char_we) char_mem[char_addr] <= head_i.wr_char;
    if (pop_o && head_i.is_read) char_rd_q <= char_mem[char_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.len_we) len_mem[head_i.slot] <= head_i.len_val;
    if (pop_o && head_i.is_read) len_rd_q <= len_mem[head_i.slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= '0;
      len0_set_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) sub_q <= last ? '0 : sub_q + SUB_W'(1);
      // slot 0 holds the empty line present after reset
      if (pop_o && head_i.len_we && (head_i.slot == '0)) len0_set_q <= 1'b1;
      if (b_ready) out_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q      <= head_i.res;
      is_read_q  <= head_i.is_read;
      line_ok_q  <= head_i.line_ok;
      col_q      <= head_i.col;
      len_zero_q <= !len0_set_q && (head_i.slot == '0);
    end
  end

  assign len_eff = len_zero_q ? '0 : len_rd_q;
  assign hit     = is_read_q && line_ok_q && ({1'b0, col_q} < len_eff);

  assign out_valid_o      = out_valid_q;
  assign read_char_o      = hit ? char_rd_q : '0;
  assign read_valid_o     = hit;
  assign line_count_o     = res_q.line_count;
  assign cursor_row_o     = res_q.cursor_row;
  assign current_length_o = res_q.current_length;
  assign dropped_oldest_o = res_q.dropped;

endmodule

### design/tlsb_checker.sv
// ---------------------------------------------------------------------------
// tlsb_checker
// Port-level checks for the text line scrollback buffer.
// ---------------------------------------------------------------------------
module tlsb_checker import tlsb_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [CHAR_W-1:0]   read_char_o,
  input logic                read_valid_o,
  input logic [COUNT_W-1:0]  line_count_o,
  input logic [LINE_W-1:0]   cursor_row_o,
  input logic [CHAR_W-1:0]   current_length_o,
  input logic                dropped_oldest_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_char_o) &&
      $stable(read_valid_o) && $stable(line_count_o) && $stable(cursor_row_o) &&
      $stable(current_length_o) && $stable(dropped_oldest_o))
    else $error("result changed while stalled");

  // stored characters are always printable; misses read as zero
  a_read_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_valid_o && (read_char_o >= 8'd32) && (read_char_o <= 8'd126)) ||
                    (!read_valid_o && (read_char_o == 8'd0)))
    else $error("bad read character");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_count_o >= 8'd1) &&
                    (line_count_o <= COUNT_W'(MAX_ROWS + SCROLLBACK)) &&
                    ({1'b0, cursor_row_o} < line_count_o))
    else $error("line count or cursor out of range");

  // a drop only happens on a commit at the storage limit
  a_drop_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_oldest_o |-> (current_length_o == 8'd0) && !read_valid_o &&
                    (line_count_o >= COUNT_W'(SCROLLBACK + 1)))
    else $error("drop without a full store commit");

endmodule

bind text_line_scrollback_buffer tlsb_checker u_tlsb_checker (.*);
